// ----- hw/rtl/rational_arithmetic_unit_assert.svh -----
// Assertion macros shared by the rational arithmetic checker.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Assert that an antecedent implies a consequent in the next cycle.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/rau_pkg.sv -----
// Types and constants of the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2
    } status_t;
endpackage

// ----- hw/rtl/rau_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rau_divider #(
    parameter int W = 33
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  q_reg;
    logic [W-1:0]  r_reg;
    logic [W-1:0]  d_reg;
    logic          done_reg;
    logic [W:0]    trial;
    logic [W:0]    diff;

    assign trial = {r_reg, q_reg[W-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
                q_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
            end
            else if (busy_reg)
            begin
                if (diff[W])
                begin
                    r_reg <= trial[W-1:0];
                    q_reg <= {q_reg[W-2:0], 1'b0};
                end
                else
                begin
                    r_reg <= diff[W-1:0];
                    q_reg <= {q_reg[W-2:0], 1'b1};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule

// ----- hw/rtl/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit.
`timescale 1ns / 1ps
// Rational arithmetic unit: takes two signed fractions and an opcode (add,
// subtract, multiply, divide) on s_axis, forms the cross products with one
// shared multiplier, reduces them by a Euclidean gcd and returns the reduced
// fraction and a status on m_axis. Remainders and the final divisions by the
// gcd all run on one restoring divider of 2*OPERAND_WIDTH+1 bits, one bit a
// cycle. Only one item is in flight; s_axis_tready stays low until the
// result is taken. Errors return 0/1 without division.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // opcode, a_num, a_den, b_num, b_den
    input  logic [((4*OPERAND_WIDTH+2+7)/8)*8-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // res_num, res_den, status
    output logic [((4*OPERAND_WIDTH+4+7)/8)*8-1:0] m_axis_tdata
);
    import rau_pkg::*;

    localparam int OW  = OPERAND_WIDTH;
    localparam int RW  = 2 * OW + 1;
    localparam int IDW = ((4 * OW + 2 + 7) / 8) * 8;
    localparam int ODW = ((2 * RW + 2 + 7) / 8) * 8;

    typedef enum logic [3:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_COMB, S_GCD, S_GWAIT,
        S_DN, S_DNW, S_DD, S_DDW, S_OUT
    } state_t;

    state_t              state_reg;
    logic [1:0]          op_reg;
    logic signed [OW-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [RW-1:0] p0_reg, p1_reg, num_reg, den_reg;
    logic [RW-1:0]       gx_reg, gy_reg, g_reg;
    logic [RW-1:0]       rnum_reg, rden_reg;
    logic [1:0]          status_reg;
    logic                out_valid_reg;

    logic signed [OW-1:0] mul_a, mul_b;
    logic signed [RW-1:0] prod;
    logic                dstart;
    logic [RW-1:0]       dividend, divisor, quo, rem;
    logic                ddone;
    logic [RW-1:0]       mag_num, mag_den;

    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        case (state_reg)
            S_M0:    begin mul_a = an_reg; mul_b = (op_reg == OP_MUL) ? bn_reg : bd_reg; end
            S_M1:    begin mul_a = bn_reg; mul_b = ad_reg; end
            S_M2:    begin mul_a = ad_reg; mul_b = (op_reg == OP_DIV) ? bn_reg : bd_reg; end
            default: begin mul_a = an_reg; mul_b = bd_reg; end
        endcase
    end

    assign prod    = RW'(mul_a) * RW'(mul_b);
    assign mag_num = num_reg[RW-1] ? RW'(-num_reg) : RW'(num_reg);
    assign mag_den = den_reg[RW-1] ? RW'(-den_reg) : RW'(den_reg);

    always_comb
    begin
        dstart   = 1'b0;
        dividend = gx_reg;
        divisor  = gy_reg;
        case (state_reg)
            S_GCD: dstart = (gy_reg != '0);
            S_DN:  begin dstart = 1'b1; dividend = mag_num; divisor = g_reg; end
            S_DD:  begin dstart = 1'b1; dividend = mag_den; divisor = g_reg; end
            default: dstart = 1'b0;
        endcase
    end

    rau_divider #(.W(RW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dstart),
        .dividend  (dividend),
        .divisor   (divisor),
        .done      (ddone),
        .quotient  (quo),
        .remainder (rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg <= s_axis_tdata[1:0];
                        an_reg <= s_axis_tdata[2+OW-1:2];
                        ad_reg <= s_axis_tdata[2+2*OW-1:2+OW];
                        bn_reg <= s_axis_tdata[2+3*OW-1:2+2*OW];
                        bd_reg <= s_axis_tdata[2+4*OW-1:2+3*OW];
                        state_reg <= S_M3;
                    end
                end
                S_M3:
                begin
                    rnum_reg <= '0;
                    rden_reg <= RW'(1);
                    if (ad_reg == '0 || bd_reg == '0)
                    begin
                        status_reg    <= ST_ZERO_DEN;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else if (op_reg == OP_DIV && bn_reg == '0)
                    begin
                        status_reg    <= ST_DIV_ZERO;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        status_reg <= ST_OK;
                        state_reg  <= S_M0;
                    end
                end
                S_M0: begin p0_reg <= prod; state_reg <= S_M1; end
                S_M1: begin p1_reg <= prod; state_reg <= S_M2; end
                S_M2:
                begin
                    den_reg   <= prod;
                    state_reg <= S_COMB;
                end
                S_COMB:
                begin
                    case (op_reg)
                        OP_ADD:  num_reg <= p0_reg + p1_reg;
                        OP_SUB:  num_reg <= p0_reg - p1_reg;
                        default: num_reg <= p0_reg;
                    endcase
                    state_reg <= S_GCD;
                    gx_reg    <= '0;
                    gy_reg    <= '0;
                end
                S_GCD:
                begin
                    if (gx_reg == '0 && gy_reg == '0)
                    begin
                        gx_reg <= mag_den;
                        gy_reg <= mag_num;
                        if (mag_den == '0 && mag_num == '0)
                        begin
                            g_reg     <= RW'(1);
                            state_reg <= S_DN;
                        end
                    end
                    else if (gy_reg == '0)
                    begin
                        g_reg     <= gx_reg;
                        state_reg <= S_DN;
                    end
                    else
                        state_reg <= S_GWAIT;
                end
                S_GWAIT:
                begin
                    if (ddone)
                    begin
                        gx_reg <= gy_reg;
                        gy_reg <= rem;
                        if (rem == '0)
                        begin
                            g_reg     <= gy_reg;
                            state_reg <= S_DN;
                        end
                        else
                            state_reg <= S_GCD;
                    end
                end
                S_DN:  state_reg <= S_DNW;
                S_DNW:
                begin
                    if (ddone)
                    begin
                        rnum_reg  <= num_reg[RW-1] ? RW'(-quo) : quo;
                        state_reg <= S_DD;
                    end
                end
                S_DD:  state_reg <= S_DDW;
                S_DDW:
                begin
                    if (ddone)
                    begin
                        rden_reg      <= den_reg[RW-1] ? RW'(-quo) : quo;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = ODW'({status_reg, rden_reg, rnum_reg});
endmodule

// ----- hw/rtl/rau_checker.sv -----
// Port checker for the rational arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_assert.svh"
module rau_checker (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready
);
    `RAU_ASSERT_IMPL(a_one_in_flight, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    `RAU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `RAU_ASSERT_NEXT(a_out_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `RAU_ASSERT_NEXT(a_ready_after_out, clk, rst_n, m_axis_tvalid && m_axis_tready, s_axis_tready)
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
